[hw/rtl/ellipse_polyline_generator_unit_defines.svh]
// Assertion macros shared by the RTL of the ellipse polyline generator.
// In synthesis builds the macros expand to nothing.
`ifndef ELLIPSE_POLYLINE_GENERATOR_UNIT_DEFINES_SVH
`define ELLIPSE_POLYLINE_GENERATOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define EPG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ellipse polyline generator: same-cycle check failed");
`define EPG_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ellipse polyline generator: next-cycle check failed");
`else
`define EPG_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define EPG_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

[hw/rtl/epg_pkg.sv]
`timescale 1ns / 1ps

package epg_pkg;

	localparam int X_COORD_BITS_DEF = 10;
	localparam int Y_BITS = 8;
	localparam int SCREEN_W_BITS = 11;
	localparam int SCREEN_H_BITS = 9;
	localparam int CLAMP_BITS = 17;
	localparam int STEP_BITS = 6;
	localparam int COEF_BITS = 8;

	localparam logic [SCREEN_W_BITS-1:0] WIDTH_RESET = 11'd256;
	localparam logic [SCREEN_H_BITS-1:0] HEIGHT_RESET = 9'd192;

	localparam logic [STEP_BITS-1:0] LAST_STEP = 6'd63;
	localparam logic [STEP_BITS-1:0] SINE_SHIFT = 6'd48;

	localparam logic [0:0] REG_SCREEN_WIDTH = 1'b0;
	localparam logic [0:0] REG_SCREEN_HEIGHT = 1'b1;

	typedef logic signed [COEF_BITS-1:0] coef_t;

	localparam coef_t COS_TABLE [64] = '{
		8'sd64, 8'sd64, 8'sd63, 8'sd61, 8'sd59, 8'sd56, 8'sd53, 8'sd49,
		8'sd45, 8'sd41, 8'sd36, 8'sd30, 8'sd24, 8'sd19, 8'sd12, 8'sd6,
		8'sd0, -8'sd6, -8'sd12, -8'sd19, -8'sd24, -8'sd30, -8'sd36, -8'sd41,
		-8'sd45, -8'sd49, -8'sd53, -8'sd56, -8'sd59, -8'sd61, -8'sd63, -8'sd64,
		-8'sd64, -8'sd64, -8'sd63, -8'sd61, -8'sd59, -8'sd56, -8'sd53, -8'sd49,
		-8'sd45, -8'sd41, -8'sd36, -8'sd30, -8'sd24, -8'sd19, -8'sd12, -8'sd6,
		8'sd0, 8'sd6, 8'sd12, 8'sd19, 8'sd24, 8'sd30, 8'sd36, 8'sd41,
		8'sd45, 8'sd49, 8'sd53, 8'sd56, 8'sd59, 8'sd61, 8'sd63, 8'sd64
	};

	function automatic coef_t cos_lookup(input logic [STEP_BITS-1:0] idx);
		return COS_TABLE[idx];
	endfunction

endpackage

[hw/rtl/epg_point_unit.sv]
`timescale 1ns / 1ps

module epg_point_unit
	import epg_pkg::*;
#(
	parameter int X_BITS = X_COORD_BITS_DEF
) (
	input  logic              clk,
	input  coef_t             coef,
	input  logic [X_BITS-2:0] radius,
	input  logic [X_BITS-1:0] center,
	input  logic [X_BITS-1:0] lim,
	output logic [X_BITS-1:0] result
);

	localparam int PW = X_BITS + COEF_BITS;
	localparam int OW = PW - 6;
	localparam int VW = X_BITS + 3;

	logic signed [PW-1:0] prod_s1;
	logic [X_BITS-1:0] center_s1;
	logic [X_BITS-1:0] lim_s1;
	logic [X_BITS-1:0] result_s2;

	logic signed [PW-1:0] prod_adj;
	logic signed [OW-1:0] offset;
	logic signed [VW-1:0] sum;

	always_ff @(posedge clk) begin
		prod_s1 <= coef * $signed({1'b0, radius});
		center_s1 <= center;
		lim_s1 <= lim;
	end

	// Division by 64 truncates toward zero: negative products are biased first.
	assign prod_adj = prod_s1 + $signed({{(PW-7){1'b0}}, 1'b0, {6{prod_s1[PW-1]}}});
	assign offset = prod_adj[PW-1:6];
	assign sum = $signed({3'b000, center_s1}) + $signed({offset[OW-1], offset});

	always_ff @(posedge clk) begin
		if (sum[VW-1]) begin
			result_s2 <= '0;
		end else if (sum[VW-2:0] > {2'b00, lim_s1}) begin
			result_s2 <= lim_s1;
		end else begin
			result_s2 <= sum[X_BITS-1:0];
		end
	end

	assign result = result_s2;

endmodule

[hw/rtl/ellipse_polyline_generator_unit.sv]
`timescale 1ns / 1ps
// Ellipse polyline generator.
// The slave stream carries one request per transfer: two opposite corners of a
// bounding box. The master stream returns 64 chord segments of the inscribed
// ellipse, in angle order, each with its start and end point clamped to the
// screen; tlast marks the 64th segment. Screen size is set through the write
// port (register 0 is the width, register 1 the height); the user must do so
// only while the block is idle, as the block itself does not enforce it.
// One shared multiply and clamp unit computes every point, x then y, through
// its product and result registers. tready on the slave side is high only
// while no request is in progress, so a new request waits for the current one.
// A finished segment sits in the output register; when the receiver stalls, the
// sequencer waits with the next segment computed and resumes on the transfer.
// Reset returns the block to idle, drops any pending segment and restores the
// screen size to 256 by 192.

`include "ellipse_polyline_generator_unit_defines.svh"

module ellipse_polyline_generator_unit
	import epg_pkg::*;
#(
	parameter int X_COORD_BITS = X_COORD_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,

	input  logic cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [SCREEN_W_BITS-1:0] cfg_wdata,

	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// Fields from bit 0: corner_a_x, corner_a_y, corner_b_x, corner_b_y, zero fill.
	input  logic [((2*X_COORD_BITS+2*Y_BITS+7)/8)*8-1:0] s_axis_tdata,

	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// Fields from bit 0: start_x, start_y, end_x, end_y, zero fill.
	output logic [((2*X_COORD_BITS+2*Y_BITS+7)/8)*8-1:0] m_axis_tdata,
	output logic m_axis_tlast
);

	localparam int XB = X_COORD_BITS;
	localparam int DW = ((2*XB+2*Y_BITS+7)/8)*8;
	localparam logic [XB-1:0] X_MAX = '1;
	localparam logic [Y_BITS-1:0] Y_MAX = '1;

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_ISSUE_X = 3'd1;
	localparam logic [2:0] ST_ISSUE_Y = 3'd2;
	localparam logic [2:0] ST_TAKE_X  = 3'd3;
	localparam logic [2:0] ST_TAKE_Y  = 3'd4;
	localparam logic [2:0] ST_EMIT    = 3'd5;

	logic [SCREEN_W_BITS-1:0] screen_width_q;
	logic [SCREEN_H_BITS-1:0] screen_height_q;

	logic [2:0] state_q;
	logic [STEP_BITS-1:0] seg_q;
	logic first_q;

	logic [XB-1:0] cx_q;
	logic [Y_BITS-1:0] cy_q;
	logic [XB-2:0] rx_q;
	logic [Y_BITS-2:0] ry_q;
	logic [XB-1:0] px_q;
	logic [Y_BITS-1:0] py_q;
	logic [XB-1:0] sx_q;
	logic [Y_BITS-1:0] sy_q;

	logic [DW-1:0] tdata_q;
	logic tlast_q;
	logic tvalid_q;

	logic s_fire;
	logic emit_go;
	logic [XB-1:0] ax, bx;
	logic [Y_BITS-1:0] ay, by;
	logic [XB:0] sum_x;
	logic [Y_BITS:0] sum_y;
	logic [XB-1:0] diff_x;
	logic [Y_BITS-1:0] diff_y;
	logic [XB-1:0] lim_x;
	logic [Y_BITS-1:0] lim_y;
	logic [CLAMP_BITS-1:0] wm1;
	logic [SCREEN_H_BITS-1:0] hm1;
	logic [STEP_BITS-1:0] pt_idx;

	coef_t u_coef;
	logic [XB-2:0] u_radius;
	logic [XB-1:0] u_center;
	logic [XB-1:0] u_lim;
	logic [XB-1:0] u_result;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_fire = s_axis_tvalid && s_axis_tready;
	assign emit_go = (state_q == ST_EMIT) && (!tvalid_q || m_axis_tready);

	assign ax = s_axis_tdata[XB-1:0];
	assign ay = s_axis_tdata[XB+Y_BITS-1:XB];
	assign bx = s_axis_tdata[2*XB+Y_BITS-1:XB+Y_BITS];
	assign by = s_axis_tdata[2*XB+2*Y_BITS-1:2*XB+Y_BITS];

	assign sum_x = {1'b0, ax} + {1'b0, bx};
	assign sum_y = {1'b0, ay} + {1'b0, by};
	assign diff_x = (ax > bx) ? (ax - bx) : (bx - ax);
	assign diff_y = (ay > by) ? (ay - by) : (by - ay);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q <= WIDTH_RESET;
			screen_height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SCREEN_WIDTH: screen_width_q <= cfg_wdata;
				REG_SCREEN_HEIGHT: screen_height_q <= cfg_wdata[SCREEN_H_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		wm1 = CLAMP_BITS'(screen_width_q) - CLAMP_BITS'(1);
		if (screen_width_q == '0) begin
			lim_x = '0;
		end else if (wm1 > CLAMP_BITS'(X_MAX)) begin
			lim_x = X_MAX;
		end else begin
			lim_x = wm1[XB-1:0];
		end
	end

	always_comb begin
		hm1 = screen_height_q - SCREEN_H_BITS'(1);
		if (screen_height_q == '0) begin
			lim_y = '0;
		end else if (hm1 > SCREEN_H_BITS'(Y_MAX)) begin
			lim_y = Y_MAX;
		end else begin
			lim_y = hm1[Y_BITS-1:0];
		end
	end

	assign pt_idx = first_q ? '0 : (seg_q + STEP_BITS'(1));

	always_comb begin
		if (state_q == ST_ISSUE_Y) begin
			u_coef = cos_lookup(pt_idx + SINE_SHIFT);
			u_radius = (XB-1)'(ry_q);
			u_center = XB'(cy_q);
			u_lim = XB'(lim_y);
		end else begin
			u_coef = cos_lookup(pt_idx);
			u_radius = rx_q;
			u_center = cx_q;
			u_lim = lim_x;
		end
	end

	epg_point_unit #(
		.X_BITS(XB)
	) u_point (
		.clk(clk),
		.coef(u_coef),
		.radius(u_radius),
		.center(u_center),
		.lim(u_lim),
		.result(u_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			seg_q <= '0;
			first_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_fire) begin
						state_q <= ST_ISSUE_X;
						seg_q <= '0;
						first_q <= 1'b1;
					end
				end
				ST_ISSUE_X: state_q <= ST_ISSUE_Y;
				ST_ISSUE_Y: state_q <= ST_TAKE_X;
				ST_TAKE_X: state_q <= ST_TAKE_Y;
				ST_TAKE_Y: begin
					if (first_q) begin
						first_q <= 1'b0;
						state_q <= ST_ISSUE_X;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						if (seg_q == LAST_STEP) begin
							seg_q <= '0;
							state_q <= ST_IDLE;
						end else begin
							seg_q <= seg_q + STEP_BITS'(1);
							state_q <= ST_ISSUE_X;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			cx_q <= sum_x[XB:1];
			cy_q <= sum_y[Y_BITS:1];
			rx_q <= (diff_x[XB-1:1] == '0) ? (XB-1)'(1) : diff_x[XB-1:1];
			ry_q <= (diff_y[Y_BITS-1:1] == '0) ? (Y_BITS-1)'(1) : diff_y[Y_BITS-1:1];
		end
		if (state_q == ST_TAKE_X) begin
			px_q <= u_result;
		end
		if (state_q == ST_TAKE_Y) begin
			if (first_q) begin
				sx_q <= px_q;
				sy_q <= u_result[Y_BITS-1:0];
			end else begin
				py_q <= u_result[Y_BITS-1:0];
			end
		end
		if (emit_go) begin
			sx_q <= px_q;
			sy_q <= py_q;
			tdata_q <= DW'({py_q, px_q, sy_q, sx_q});
			tlast_q <= (seg_q == LAST_STEP);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tvalid_q <= 1'b0;
		end else if (emit_go) begin
			tvalid_q <= 1'b1;
		end else if (m_axis_tready) begin
			tvalid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = tvalid_q;
	assign m_axis_tdata = tdata_q;
	assign m_axis_tlast = tlast_q;

	`EPG_ASSERT_NXT(a_accept_starts, clk, arst_n, s_fire, (state_q == ST_ISSUE_X) && first_q)
	`EPG_ASSERT_IMP(a_idle_index, clk, arst_n, state_q == ST_IDLE, seg_q == '0)
	`EPG_ASSERT_NXT(a_last_done, clk, arst_n, emit_go && (seg_q == LAST_STEP), s_axis_tready && m_axis_tvalid && m_axis_tlast)

endmodule
